// ----- rtl/core/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// shared widths, codes and defaults of the cursor linked list engine
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  // parameter defaults
  localparam int unsigned NODE_COUNT_DEF = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/core/cursor_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// static linked list with a free chain, kept in a link memory and a value
// memory, walked one link per cycle by a small sequencer
// ----------------------------------------------------------------------------
// usage:
//   slave channel: one request per transfer, tuser carries the opcode
//   (insert, remove, get, clear), tdata the position and the insert value
//   master channel: one result per request, tuser carries the status,
//   tdata the value read or removed and the entry count after the request
//   the walk reads one link per cycle from the link memory; the walk
//   therefore grows longer with the position
//   s_axis_tready_o is high only while the sequencer is idle, one
//   request is worked on at a time
//   the result sits in an output register: the next request is taken while
//   it waits, and a finished result holds the sequencer until the receiver
//   takes the one before it
//   after reset a clearing pass over all N link entries rebuilds the free chain in the
//   link memory; no request is taken during it. a clear request runs the
//   same pass. the value memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_linked_list_engine #(
  parameter int unsigned NODE_COUNT = cle_pkg::NODE_COUNT_DEF,
  parameter int unsigned VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request channel
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: position [5:0], value_in [37:6], zero [39:38]
  input  wire logic [cle_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: opcode [1:0]
  input  wire logic [cle_pkg::OPCODE_W-1:0]   s_axis_tuser_i,
  // result channel
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata: value_out [31:0], count [37:32], zero [39:38]
  output logic      [cle_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // tuser: status [1:0]
  output logic      [cle_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  import cle_pkg::*;

  localparam int unsigned AW    = $clog2(NODE_COUNT);
  localparam int unsigned CMP_W = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam logic [AW-1:0] HEAD_NODE = AW'(NODE_COUNT - 1);
  localparam logic [AW-1:0] LAST_FREE = AW'(NODE_COUNT - 2);
  localparam logic [AW-1:0] FREE_HEAD = '0;

  // one-hot sequencer states
  typedef enum logic [13:0] {
    S_CLR   = 14'h0001,
    S_IDLE  = 14'h0002,
    S_WALK  = 14'h0004,
    S_INS_A = 14'h0008,
    S_INS_B = 14'h0010,
    S_INS_C = 14'h0020,
    S_INS_D = 14'h0040,
    S_INS_E = 14'h0080,
    S_REM_A = 14'h0100,
    S_REM_B = 14'h0200,
    S_REM_C = 14'h0400,
    S_REM_D = 14'h0800,
    S_REM_E = 14'h1000,
    S_OUT   = 14'h2000
  } state_e;

  // control registers
  state_e              state_q, state_d;
  opcode_e             op_q, op_d;
  logic [POS_W-1:0]    steps_q, steps_d;
  logic                hop_q, hop_d;
  logic [AW-1:0]       count_q, count_d;
  logic [AW-1:0]       clr_idx_q, clr_idx_d;
  logic                clr_emit_q, clr_emit_d;
  logic                out_valid_q, out_valid_d;

  // payload registers
  logic [AW-1:0]         prev_q, prev_d;
  logic [AW-1:0]         node_q, node_d;      // fresh node or removal target
  logic [VALUE_BITS-1:0] vin_q, vin_d;
  status_e               status_q, status_d;
  logic [DATA_W-1:0]     vout_q, vout_d;
  status_e               out_status_q, out_status_d;
  logic [DATA_W-1:0]     out_value_q, out_value_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;

  // memory ports
  logic                  link_we;
  logic [AW-1:0]         link_waddr, link_wdata, link_raddr, link_rdata;
  logic                  val_we;
  logic [AW-1:0]         val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;

  // request fields
  opcode_e            in_op;
  logic [POS_W-1:0]   in_pos;
  logic signed [DATA_W-1:0] in_value;
  logic signed [63:0] in_value_ext;
  logic               s_fire;
  logic [CMP_W-1:0]   pos_c, cnt_c;
  logic [AW-1:0]      cur_node;
  logic               out_free;

  assign in_op        = opcode_e'(s_axis_tuser_i);
  assign in_pos       = s_axis_tdata_i[POS_W-1:0];
  assign in_value     = s_axis_tdata_i[POS_W+DATA_W-1:POS_W];
  assign in_value_ext = 64'(in_value);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign pos_c           = CMP_W'(in_pos);
  assign cnt_c           = CMP_W'(count_q);

  // walk pointer: the link just read, or the start node on the first hop
  assign cur_node = hop_q ? link_rdata : prev_q;

  // output register can take a new result
  assign out_free = !out_valid_q || m_axis_tready_i;

  cle_ram #(
    .WIDTH (AW),
    .DEPTH (NODE_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  cle_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (NODE_COUNT)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    steps_d      = steps_q;
    hop_d        = hop_q;
    count_d      = count_q;
    clr_idx_d    = clr_idx_q;
    clr_emit_d   = clr_emit_q;
    out_valid_d  = out_valid_q;
    prev_d       = prev_q;
    node_d       = node_q;
    vin_d        = vin_q;
    status_d     = status_q;
    vout_d       = vout_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;

    link_we    = 1'b0;
    link_waddr = prev_q;
    link_wdata = node_q;
    link_raddr = prev_q;
    val_we     = 1'b0;
    val_waddr  = node_q;
    val_wdata  = vin_q;
    val_raddr  = link_rdata;

    // receiver drains the output register
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        // rebuild the free chain one entry per cycle
        link_we    = 1'b1;
        link_waddr = clr_idx_q;
        link_wdata = (clr_idx_q < LAST_FREE) ? clr_idx_q + AW'(1) : FREE_HEAD;
        count_d    = '0;
        clr_idx_d  = clr_idx_q + AW'(1);
        if (clr_idx_q == HEAD_NODE) begin
          clr_idx_d = '0;
          state_d   = clr_emit_q ? S_OUT : S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_fire) begin
          op_d     = in_op;
          steps_d  = in_pos - POS_W'(1);
          hop_d    = 1'b0;
          prev_d   = HEAD_NODE;
          vin_d    = VALUE_BITS'(in_value_ext);
          vout_d   = '0;
          status_d = ST_OK;
          case (in_op)
            OP_INSERT: begin
              if (in_pos == '0 || pos_c > cnt_c + CMP_W'(1)) begin
                status_d = ST_RANGE;
                state_d  = S_OUT;
              end else if (count_q == LAST_FREE) begin
                // every node but the two heads is in use
                status_d = ST_FULL;
                state_d  = S_OUT;
              end else begin
                state_d = S_WALK;
              end
            end
            OP_REMOVE, OP_GET: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_OUT;
              end else if (in_pos == '0 || pos_c > cnt_c) begin
                status_d = ST_RANGE;
                state_d  = S_OUT;
              end else begin
                state_d = S_WALK;
              end
            end
            default: begin
              clr_emit_d = 1'b1;
              clr_idx_d  = '0;
              state_d    = S_CLR;
            end
          endcase
        end
      end

      S_WALK: begin
        // one hop per cycle, the read address is the link just returned
        if (steps_q == '0) begin
          prev_d  = cur_node;
          state_d = (op_q == OP_INSERT) ? S_INS_A : S_REM_A;
        end else begin
          link_raddr = cur_node;
          prev_d     = cur_node;
          hop_d      = 1'b1;
          steps_d    = steps_q - POS_W'(1);
        end
      end

      // insert: fresh = next(0); next(0) = next(fresh);
      // next(fresh) = next(prev); next(prev) = fresh
      S_INS_A: begin
        link_raddr = FREE_HEAD;
        state_d    = S_INS_B;
      end

      S_INS_B: begin
        node_d     = link_rdata;
        link_raddr = link_rdata;
        state_d    = S_INS_C;
      end

      S_INS_C: begin
        link_we    = 1'b1;
        link_waddr = FREE_HEAD;
        link_wdata = link_rdata;
        link_raddr = prev_q;
        state_d    = S_INS_D;
      end

      S_INS_D: begin
        link_we    = 1'b1;
        link_waddr = node_q;
        link_wdata = link_rdata;
        val_we     = 1'b1;
        val_waddr  = node_q;
        val_wdata  = vin_q;
        state_d    = S_INS_E;
      end

      S_INS_E: begin
        link_we    = 1'b1;
        link_waddr = prev_q;
        link_wdata = node_q;
        count_d    = count_q + AW'(1);
        state_d    = S_OUT;
      end

      // remove: target = next(prev); next(prev) = next(target);
      // next(target) = next(0); next(0) = target
      S_REM_A: begin
        link_raddr = prev_q;
        state_d    = S_REM_B;
      end

      S_REM_B: begin
        node_d     = link_rdata;
        link_raddr = link_rdata;
        val_raddr  = link_rdata;
        state_d    = S_REM_C;
      end

      S_REM_C: begin
        vout_d = DATA_W'(val_rdata);
        if (op_q == OP_GET) begin
          state_d = S_OUT;
        end else begin
          link_we    = 1'b1;
          link_waddr = prev_q;
          link_wdata = link_rdata;
          link_raddr = FREE_HEAD;
          state_d    = S_REM_D;
        end
      end

      S_REM_D: begin
        link_we    = 1'b1;
        link_waddr = node_q;
        link_wdata = link_rdata;
        state_d    = S_REM_E;
      end

      S_REM_E: begin
        link_we    = 1'b1;
        link_waddr = FREE_HEAD;
        link_wdata = node_q;
        count_d    = count_q - AW'(1);
        state_d    = S_OUT;
      end

      S_OUT: begin
        // hand the result over once the output register is free
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_value_d  = vout_q;
          out_count_d  = COUNT_W'(count_q);
          clr_emit_d   = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      op_q        <= OP_INSERT;
      steps_q     <= '0;
      hop_q       <= 1'b0;
      count_q     <= '0;
      clr_idx_q   <= '0;
      clr_emit_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      steps_q     <= steps_d;
      hop_q       <= hop_d;
      count_q     <= count_d;
      clr_idx_q   <= clr_idx_d;
      clr_emit_q  <= clr_emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    node_q       <= node_d;
    vin_q        <= vin_d;
    status_q     <= status_d;
    vout_q       <= vout_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - COUNT_W - DATA_W){1'b0}}, out_count_q, out_value_q};

  // the list never holds more than every node but the two heads
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LAST_FREE)
    else $error("entry count beyond node capacity");

  // the count moves only in the update and clearing states
  a_count_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_WALK || state_q == S_OUT) |=>
      count_q == $past(count_q))
    else $error("entry count changed outside an update");

  // a walk never ends on the free head
  a_prev_not_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_E || state_q == S_REM_C) |-> prev_q != FREE_HEAD)
    else $error("predecessor is the free head");

  // a result leaving the sequencer shows up on the master side, and the sequencer is idle again
  a_result_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> m_axis_tvalid_o && s_axis_tready_o)
    else $error("result lost on hand-over");

endmodule

`default_nettype wire

// ----- rtl/core/cle_ram.sv -----
// ----------------------------------------------------------------------------
// cle_ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
